// ===== design/yrpp_pkg.sv =====
// yrpp_pkg: shared types, fixed-point coefficients and the saturation helper
// for the yuv to rgb pixel pair converter. no dependencies.
`default_nettype none

package yrpp_pkg;

	// offsets removed from the raw samples
	localparam logic signed [9:0] LUMA_OFFSET   = 10'sd16;
	localparam logic signed [9:0] CHROMA_OFFSET = 10'sd127;

	// coefficients scaled by 2**FRAC_BITS
	localparam logic signed [7:0] COEF_Y  = 8'sd37;
	localparam logic signed [7:0] COEF_RV = 8'sd51;
	localparam logic signed [7:0] COEF_BU = 8'sd65;
	localparam logic signed [7:0] COEF_GU = 8'sd13;
	localparam logic signed [7:0] COEF_GV = 8'sd26;

	localparam int FRAC_BITS = 5;
	localparam int SUM_W     = 16;

	typedef logic [7:0] sample_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		sample_t red;
		sample_t green;
		sample_t blue;
	} rgb_t;

	// floor shift by FRAC_BITS, then clamp to 0..255
	function automatic sample_t clamp_shift(input sum_t sum);
		sample_t res;
		if (sum[SUM_W-1]) begin
			res = 8'd0;
		end else if (|sum[SUM_W-2:FRAC_BITS+8]) begin
			res = 8'hff;
		end else begin
			res = sum[FRAC_BITS+7:FRAC_BITS];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== design/yrpp_pixel.sv =====
// yrpp_pixel: combinational conversion of one yuv pixel to saturated rgb.
// depends on yrpp_pkg.
`default_nettype none

module yrpp_pixel (
	input  wire yrpp_pkg::sample_t luma,
	input  wire yrpp_pkg::sample_t cb,
	input  wire yrpp_pkg::sample_t cr,
	output yrpp_pkg::rgb_t         rgb
);

	logic signed [9:0] yp;
	logic signed [9:0] up;
	logic signed [9:0] vp;
	yrpp_pkg::sum_t    ys;
	yrpp_pkg::sum_t    sum_r;
	yrpp_pkg::sum_t    sum_g;
	yrpp_pkg::sum_t    sum_b;

	// centered samples, y' in -16..239, u' and v' in -127..128
	assign yp = signed'({2'b00, luma}) - yrpp_pkg::LUMA_OFFSET;
	assign up = signed'({2'b00, cb}) - yrpp_pkg::CHROMA_OFFSET;
	assign vp = signed'({2'b00, cr}) - yrpp_pkg::CHROMA_OFFSET;

	// every sum stays inside 16 signed bits
	assign ys    = 16'(yp) * 16'(yrpp_pkg::COEF_Y);
	assign sum_r = ys + 16'(vp) * 16'(yrpp_pkg::COEF_RV);
	assign sum_g = ys - (16'(up) * 16'(yrpp_pkg::COEF_GU) + 16'(vp) * 16'(yrpp_pkg::COEF_GV));
	assign sum_b = ys + 16'(up) * 16'(yrpp_pkg::COEF_BU);

	assign rgb.red   = yrpp_pkg::clamp_shift(sum_r);
	assign rgb.green = yrpp_pkg::clamp_shift(sum_g);
	assign rgb.blue  = yrpp_pkg::clamp_shift(sum_b);

endmodule

`default_nettype wire

// ===== design/yuv_to_rgb_pixel_pair_unit.sv =====
// yuv_to_rgb_pixel_pair_unit: top level of the yuv to rgb pixel pair converter.
// depends on yrpp_pkg and yrpp_pixel.
`default_nettype none

// Converts one horizontal pair of yuv pixels to 8-bit rgb per beat, using
// R=(37Y'+51V')>>5, G=(37Y'-(13U'+26V'))>>5, B=(37Y'+65U')>>5 with Y'=Y-16,
// U'=Cb-127, V'=Cr-127, floor shift and saturation to 0..255. A pair is
// accepted in every cycle while pix_stall is low; it passes through the
// input register and then the result register, with the conversion logic
// between them, before it shows with rgb_valid. The input stage is released
// whenever the result register is empty or being taken, so a full result
// register held by rgb_stall still lets one more pair in before pix_stall
// rises.
// chroma_per_pixel (written on the cfg channel, bit 0 of cfg_data, reset 0)
// selects shared chroma for the pair (0, 4:2:2 / 4:2:0) or per-pixel chroma
// (1, 4:4:4). Write it only while no beat is in flight.
module yuv_to_rgb_pixel_pair_unit (
	input  wire                   clk,
	input  wire                   arst_n,

	// configuration write channel
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire                   cfg_data,

	// yuv pair input channel
	input  wire                   pix_valid,
	output logic                  pix_stall,
	input  wire yrpp_pkg::sample_t luma_first,
	input  wire yrpp_pkg::sample_t luma_second,
	input  wire yrpp_pkg::sample_t cb_first,
	input  wire yrpp_pkg::sample_t cr_first,
	input  wire yrpp_pkg::sample_t cb_second,
	input  wire yrpp_pkg::sample_t cr_second,

	// rgb pair output channel
	output logic                  rgb_valid,
	input  wire                   rgb_stall,
	output yrpp_pkg::sample_t     red_first,
	output yrpp_pkg::sample_t     green_first,
	output yrpp_pkg::sample_t     blue_first,
	output yrpp_pkg::sample_t     red_second,
	output yrpp_pkg::sample_t     green_second,
	output yrpp_pkg::sample_t     blue_second
);

	logic chroma_per_pixel_q;

	// input register
	logic              valid_s1;
	yrpp_pkg::sample_t luma_first_s1;
	yrpp_pkg::sample_t luma_second_s1;
	yrpp_pkg::sample_t cb_first_s1;
	yrpp_pkg::sample_t cr_first_s1;
	yrpp_pkg::sample_t cb_second_s1;
	yrpp_pkg::sample_t cr_second_s1;

	// result register
	logic           valid_s2;
	yrpp_pkg::rgb_t rgb_first_s2;
	yrpp_pkg::rgb_t rgb_second_s2;

	logic              advance;
	logic              pix_accept;
	yrpp_pkg::sample_t cb_right;
	yrpp_pkg::sample_t cr_right;
	yrpp_pkg::rgb_t    rgb_first;
	yrpp_pkg::rgb_t    rgb_second;

	// the register is a single flop, always ready for a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chroma_per_pixel_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			chroma_per_pixel_q <= cfg_data;
		end
	end

	// result register can take a new beat when empty or being drained
	assign advance    = !valid_s2 || !rgb_stall;
	assign pix_stall  = valid_s1 && !advance;
	assign pix_accept = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pix_stall) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			luma_first_s1  <= luma_first;
			luma_second_s1 <= luma_second;
			cb_first_s1    <= cb_first;
			cr_first_s1    <= cr_first;
			cb_second_s1   <= cb_second;
			cr_second_s1   <= cr_second;
		end
	end

	// right pixel takes its own chroma only in 4:4:4 mode
	assign cb_right = chroma_per_pixel_q ? cb_second_s1 : cb_first_s1;
	assign cr_right = chroma_per_pixel_q ? cr_second_s1 : cr_first_s1;

	yrpp_pixel u_pixel_first (
		.luma (luma_first_s1),
		.cb   (cb_first_s1),
		.cr   (cr_first_s1),
		.rgb  (rgb_first)
	);

	yrpp_pixel u_pixel_second (
		.luma (luma_second_s1),
		.cb   (cb_right),
		.cr   (cr_right),
		.rgb  (rgb_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rgb_first_s2  <= rgb_first;
			rgb_second_s2 <= rgb_second;
		end
	end

	assign rgb_valid    = valid_s2;
	assign red_first    = rgb_first_s2.red;
	assign green_first  = rgb_first_s2.green;
	assign blue_first   = rgb_first_s2.blue;
	assign red_second   = rgb_second_s2.red;
	assign green_second = rgb_second_s2.green;
	assign blue_second  = rgb_second_s2.blue;

	// input side only stalls while a beat sits in the input register
	a_stall_needs_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> valid_s1)
		else $error("pix_stall without a beat in the input register");

	// a free or draining result register never holds back the input
	a_no_stall_on_drain : assert property (@(posedge clk) disable iff (!arst_n)
		(!rgb_valid || !rgb_stall) |-> !pix_stall)
		else $error("input stalled while result register can advance");

	// an accepted pair lands in the input register
	a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		pix_accept |=> valid_s1)
		else $error("accepted pair lost before the input register");

	// a moving input beat reaches the result register next cycle
	a_s1_moves_to_s2 : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> rgb_valid)
		else $error("beat dropped between input and result register");

endmodule

`default_nettype wire

// ===== verif/tb_yuv_to_rgb_pixel_pair_unit.sv =====
// tb_yuv_to_rgb_pixel_pair_unit: self-checking testbench for the yuv to rgb pixel pair
// converter, with a small scoreboard class that predicts each rgb beat.
// depends on yrpp_pkg and yuv_to_rgb_pixel_pair_unit.
`default_nettype none

// expected rgb of one accepted yuv pair
typedef struct {
	yrpp_pkg::rgb_t left;
	yrpp_pkg::rgb_t right;
} rgb_pair_t;

class rgb_pair_scoreboard;
	bit          per_pixel;
	rgb_pair_t   pending_rgb_q[$];
	int unsigned errors;

	// floor shift by 5, then clamp to 0..255
	function yrpp_pkg::sample_t saturate(int sum);
		int q;
		if (sum < 0) begin
			return 8'd0;
		end
		q = sum >>> 5;
		if (q > 255) begin
			return 8'd255;
		end
		return q[7:0];
	endfunction

	function yrpp_pkg::rgb_t convert_pixel(yrpp_pkg::sample_t y, yrpp_pkg::sample_t cb,
			yrpp_pkg::sample_t cr);
		int y_ofs;
		int u_ofs;
		int v_ofs;
		int y_term;
		yrpp_pkg::rgb_t px;
		y_ofs  = int'(y) - 16;
		u_ofs  = int'(cb) - 127;
		v_ofs  = int'(cr) - 127;
		y_term = 37 * y_ofs;
		px.red   = saturate(y_term + 51 * v_ofs);
		px.green = saturate(y_term - (13 * u_ofs + 26 * v_ofs));
		px.blue  = saturate(y_term + 65 * u_ofs);
		return px;
	endfunction

	function void note_pair(yrpp_pkg::sample_t luma_l, yrpp_pkg::sample_t luma_r,
			yrpp_pkg::sample_t cb_l, yrpp_pkg::sample_t cr_l,
			yrpp_pkg::sample_t cb_r, yrpp_pkg::sample_t cr_r);
		rgb_pair_t want;
		want.left = convert_pixel(luma_l, cb_l, cr_l);
		if (per_pixel) begin
			want.right = convert_pixel(luma_r, cb_r, cr_r);
		end else begin
			want.right = convert_pixel(luma_r, cb_l, cr_l);
		end
		pending_rgb_q.push_back(want);
	endfunction

	task report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task check_pair(yrpp_pkg::rgb_t got_l, yrpp_pkg::rgb_t got_r);
		rgb_pair_t want;
		if (pending_rgb_q.size() == 0) begin
			report_mismatch("rgb beat with no pair pending", 1, 0);
			return;
		end
		want = pending_rgb_q.pop_front();
		if (got_l.red !== want.left.red)
			report_mismatch("red_first", got_l.red, want.left.red);
		if (got_l.green !== want.left.green)
			report_mismatch("green_first", got_l.green, want.left.green);
		if (got_l.blue !== want.left.blue)
			report_mismatch("blue_first", got_l.blue, want.left.blue);
		if (got_r.red !== want.right.red)
			report_mismatch("red_second", got_r.red, want.right.red);
		if (got_r.green !== want.right.green)
			report_mismatch("green_second", got_r.green, want.right.green);
		if (got_r.blue !== want.right.blue)
			report_mismatch("blue_second", got_r.blue, want.right.blue);
	endtask
endclass

module tb_yuv_to_rgb_pixel_pair_unit;

	localparam int PHASES       = 8;
	localparam int PAIRS_PER_PH = 180;
	localparam int LONG_HOLD    = 60;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_data;
	logic              pix_valid;
	logic              pix_stall;
	yrpp_pkg::sample_t luma_first;
	yrpp_pkg::sample_t luma_second;
	yrpp_pkg::sample_t cb_first;
	yrpp_pkg::sample_t cr_first;
	yrpp_pkg::sample_t cb_second;
	yrpp_pkg::sample_t cr_second;
	logic              rgb_valid;
	logic              rgb_stall;
	yrpp_pkg::sample_t red_first;
	yrpp_pkg::sample_t green_first;
	yrpp_pkg::sample_t blue_first;
	yrpp_pkg::sample_t red_second;
	yrpp_pkg::sample_t green_second;
	yrpp_pkg::sample_t blue_second;

	rgb_pair_scoreboard sb = new();

	// idle shaping: upper bound of the per-beat wait on each side
	int unsigned tx_max_gap;
	int unsigned rx_max_gap;
	// receiver countdown and a one-shot request for a long hold-off
	int unsigned rx_hold;
	int unsigned long_hold_req;

	yuv_to_rgb_pixel_pair_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.luma_first   (luma_first),
		.luma_second  (luma_second),
		.cb_first     (cb_first),
		.cr_first     (cr_first),
		.cb_second    (cb_second),
		.cr_second    (cr_second),
		.rgb_valid    (rgb_valid),
		.rgb_stall    (rgb_stall),
		.red_first    (red_first),
		.green_first  (green_first),
		.blue_first   (blue_first),
		.red_second   (red_second),
		.green_second (green_second),
		.blue_second  (blue_second)
	);

	// free-running clock, period 12
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// hard limit on the run, far beyond the slowest legal run
	initial begin
		#(12 * 400000);
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: stall is updated once per falling edge from the countdown,
	// a long hold-off request overrides whatever was drawn for the last beat
	always @(negedge clk) begin
		if (long_hold_req != 0) begin
			rx_hold = long_hold_req;
			long_hold_req = 0;
		end
		rgb_stall = (rx_hold != 0);
		if (rx_hold != 0) begin
			rx_hold--;
		end
	end

	// result monitor: every accepted rgb beat is checked against the oldest
	// pending pair, then the receiver draws its wait before the next beat
	always @(posedge clk) begin
		if (arst_n && rgb_valid === 1'b1 && rgb_stall === 1'b0) begin
			sb.check_pair('{red_first, green_first, blue_first},
				'{red_second, green_second, blue_second});
			rx_hold = $urandom_range(0, rx_max_gap);
		end
	end

	// biased sample: the offsets and the range ends show up often
	function automatic yrpp_pkg::sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd16;
			3: return 8'd127;
			4: return 8'd128;
			default: return yrpp_pkg::sample_t'($urandom_range(0, 255));
		endcase
	endfunction

	// offer one yuv pair after an idle gap set by the gap argument, hold it until taken
	task send_pair(yrpp_pkg::sample_t luma_l, yrpp_pkg::sample_t luma_r,
			yrpp_pkg::sample_t cb_l, yrpp_pkg::sample_t cr_l,
			yrpp_pkg::sample_t cb_r, yrpp_pkg::sample_t cr_r, int unsigned gap);
		@(negedge clk);
		if (gap != 0) begin
			pix_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		luma_first  = luma_l;
		luma_second = luma_r;
		cb_first    = cb_l;
		cr_first    = cr_l;
		cb_second   = cb_r;
		cr_second   = cr_r;
		pix_valid   = 1'b1;
		do begin
			@(posedge clk);
		end while (pix_stall !== 1'b0);
		sb.note_pair(luma_l, luma_r, cb_l, cr_l, cb_r, cr_r);
	endtask

	task send_random_pair();
		send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
			pick_sample(), pick_sample(), $urandom_range(0, tx_max_gap));
	endtask

	// stop offering and wait until every pending rgb beat has come back,
	// then idle on so that both pipeline stages are empty before returning
	task drain();
		@(negedge clk);
		pix_valid = 1'b0;
		while (sb.pending_rgb_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// chroma mode write, only issued with the pipeline empty
	task write_chroma_mode(bit per_pixel);
		@(negedge clk);
		cfg_data  = per_pixel;
		cfg_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (cfg_ready !== 1'b1);
		sb.per_pixel = per_pixel;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		int unsigned style;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = 1'b0;
		pix_valid     = 1'b0;
		rgb_stall     = 1'b0;
		luma_first    = '0;
		luma_second   = '0;
		cb_first      = '0;
		cr_first      = '0;
		cb_second     = '0;
		cr_second     = '0;
		rx_hold       = 0;
		long_hold_req = 0;
		tx_max_gap    = 0;
		rx_max_gap    = 0;
		sb.per_pixel  = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed, shared chroma (reset mode): second chroma must be ignored
		send_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 0);     // luma below offset
		send_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 0);   // large sums clip high
		send_pair(8'd16, 8'd16, 8'd127, 8'd127, 8'd5, 8'd250, 0);   // black, zero chroma
		send_pair(8'd235, 8'd235, 8'd128, 8'd128, 8'd0, 8'd0, 1);
		send_pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd170, 8'd85, 0);      // negative sums clip to 0
		send_pair(8'd255, 8'd0, 8'd0, 8'd255, 8'd85, 8'd170, 2);
		send_pair(8'd128, 8'd64, 8'd255, 8'd255, 8'd1, 8'd1, 0);
		send_pair(8'd100, 8'd200, 8'd0, 8'd128, 8'd254, 8'd254, 0);
		drain();

		// directed, per-pixel chroma
		write_chroma_mode(1'b1);
		send_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 0);
		send_pair(8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 0);
		send_pair(8'd16, 8'd235, 8'd127, 8'd127, 8'd128, 8'd128, 0);
		send_pair(8'd128, 8'd128, 8'd0, 8'd255, 8'd255, 8'd0, 3);
		send_pair(8'd200, 8'd50, 8'd60, 8'd240, 8'd30, 8'd10, 0);
		send_pair(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 0);
		drain();

		// random phases: mode and idle style change between phases, each
		// phase ends with the sender paused until every beat is back
		for (int ph = 0; ph < PHASES; ph++) begin
			write_chroma_mode(ph[0] ^ ph[2]);
			style = ph % 4;
			case (style)
				0: begin
					tx_max_gap = 8;
					rx_max_gap = 8;
				end
				1: begin
					// back to back on both sides
					tx_max_gap = 0;
					rx_max_gap = 0;
				end
				2: begin
					tx_max_gap = 8;
					rx_max_gap = 0;
				end
				default: begin
					tx_max_gap = 0;
					rx_max_gap = 8;
				end
			endcase
			// receiver holds off for a long stretch while pairs keep coming,
			// so both pipeline stages fill and pix_stall rises
			if (ph == 1 || ph == 5) begin
				long_hold_req = LONG_HOLD;
			end
			for (int n = 0; n < PAIRS_PER_PH; n++) begin
				send_random_pair();
			end
			drain();
		end

		// nothing pending any more; watch a while longer for stray beats
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_rgb_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
